// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion shorthands, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg
// types, register indexes and helpers shared by the compensation pipeline
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int RES_W   = 32;
	localparam int CFG_IDX_W = 3;

	// first-order datasheet constants
	localparam int TEMP_BASE   = 2000;
	localparam int COLD_BASE   = 1500;
	// (temp - 2000) at or below this means truncated temp / 100 < -15
	localparam int COLD_DEV_LIMIT = -3600;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESSURE_SENSITIVITY  = 3'd0,
		CFG_PRESSURE_OFFSET       = 3'd1,
		CFG_SENS_TEMP_COEFF       = 3'd2,
		CFG_OFFSET_TEMP_COEFF     = 3'd3,
		CFG_REFERENCE_TEMPERATURE = 3'd4,
		CFG_TEMP_SENSITIVITY      = 3'd5,
		CFG_SENSOR_MODEL          = 3'd6
	} cfg_index_t;

	// sensor_model codes
	localparam logic MODEL_2BAR  = 1'b0;
	localparam logic MODEL_30BAR = 1'b1;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [RES_W-1:0] temperature_centi;
		logic signed [RES_W-1:0] pressure_value;
	} result_t;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sens_temp_coeff;
		logic [CAL_W-1:0] offset_temp_coeff;
		logic [CAL_W-1:0] reference_temperature;
		logic [CAL_W-1:0] temp_sensitivity;
		logic             sensor_model;
	} cal_t;

	// first-order results handed to the correction stages
	typedef struct packed {
		logic [RAW_W-1:0]  d1;
		logic signed [18:0] temp;
		logic signed [17:0] dev;
		logic signed [18:0] cold_dev;
		logic signed [35:0] sens;
		logic signed [36:0] off;
		logic [16:0]        ti_low;
		logic [16:0]        ti_high;
		logic               low;
		logic               cold;
	} front_t;

	// corrected terms handed to the pressure stages
	typedef struct packed {
		logic [RAW_W-1:0]   d1;
		logic signed [19:0] temp;
		logic signed [39:0] sens;
		logic signed [40:0] off;
	} corr_t;

	// signed shift right that truncates toward zero like a c division
	function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
		input int unsigned k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

// ----- sv/ptc_cfg.sv -----
// ----------------------------------------------------------------------------
// ptc_cfg
// calibration word and model select registers behind the write port
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptc_cfg
	import ptc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_data,
	output cal_t                 cal
);

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.pressure_sensitivity  <= '0;
			cal_q.pressure_offset       <= '0;
			cal_q.sens_temp_coeff       <= '0;
			cal_q.offset_temp_coeff     <= '0;
			cal_q.reference_temperature <= '0;
			cal_q.temp_sensitivity      <= '0;
			cal_q.sensor_model          <= MODEL_30BAR;
		end else if (cfg_write_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PRESSURE_SENSITIVITY:  cal_q.pressure_sensitivity  <= cfg_data;
				CFG_PRESSURE_OFFSET:       cal_q.pressure_offset       <= cfg_data;
				CFG_SENS_TEMP_COEFF:       cal_q.sens_temp_coeff       <= cfg_data;
				CFG_OFFSET_TEMP_COEFF:     cal_q.offset_temp_coeff     <= cfg_data;
				CFG_REFERENCE_TEMPERATURE: cal_q.reference_temperature <= cfg_data;
				CFG_TEMP_SENSITIVITY:      cal_q.temp_sensitivity      <= cfg_data;
				CFG_SENSOR_MODEL:          cal_q.sensor_model          <= cfg_data[0];
				default: begin
					// index beyond the list, write dropped
				end
			endcase
		end
	end

	assign cal = cal_q;

	`ASSERT_NEXT(a_model_write, cfg_write_en && cfg_index == CFG_SENSOR_MODEL,
		cal_q.sensor_model == $past(cfg_data[0]), "sensor model write lost")

endmodule

// ----- sv/ptc_front.sv -----
// ----------------------------------------------------------------------------
// ptc_front
// stages 1 to 3: dT, calibration products, first-order temp, sens and off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptc_front
	import ptc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    valid,
	input  sample_t sample,
	input  cal_t    cal,
	output logic    out_valid,
	output front_t  front
);

	logic               v_s1, v_s2, v_s3;
	logic [RAW_W-1:0]   d1_s1, d1_s2;
	logic signed [24:0] dt_s1;
	logic signed [41:0] dtc6_s2, dtc3_s2, dtc4_s2;
	logic [47:0]        dtsq_s2;
	front_t             front_s3;

	logic signed [49:0] dtsq_full;
	logic signed [17:0] dev_n;
	logic signed [35:0] sens_n;
	logic signed [36:0] off_n;
	logic [16:0]        ti_low_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign dtsq_full = dt_s1 * dt_s1;

	always_comb begin
		dev_n = 18'(sdiv_pow2(64'(dtc6_s2), 23));
		if (cal.sensor_model == MODEL_2BAR) begin
			sens_n = $signed({4'b0, cal.pressure_sensitivity, 16'b0})
				+ 36'(sdiv_pow2(64'(dtc3_s2), 7));
			off_n = $signed({4'b0, cal.pressure_offset, 17'b0})
				+ 37'(sdiv_pow2(64'(dtc4_s2), 6));
			ti_low_n = 17'((52'(dtsq_s2) * 52'd11) >> 35);
		end else begin
			sens_n = $signed({5'b0, cal.pressure_sensitivity, 15'b0})
				+ 36'(sdiv_pow2(64'(dtc3_s2), 8));
			off_n = $signed({5'b0, cal.pressure_offset, 16'b0})
				+ 37'(sdiv_pow2(64'(dtc4_s2), 7));
			ti_low_n = 17'((50'(dtsq_s2) * 50'd3) >> 33);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= sample.raw_pressure;
			dt_s1 <= $signed({1'b0, sample.raw_temperature})
				- $signed({1'b0, cal.reference_temperature, 8'b0});

			d1_s2   <= d1_s1;
			dtc6_s2 <= dt_s1 * $signed({1'b0, cal.temp_sensitivity});
			dtc3_s2 <= dt_s1 * $signed({1'b0, cal.sens_temp_coeff});
			dtc4_s2 <= dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
			dtsq_s2 <= dtsq_full[47:0];

			front_s3.d1       <= d1_s2;
			front_s3.dev      <= dev_n;
			front_s3.temp     <= 19'(dev_n) + 19'(TEMP_BASE);
			front_s3.cold_dev <= 19'(dev_n) + 19'(TEMP_BASE + COLD_BASE);
			front_s3.sens     <= sens_n;
			front_s3.off      <= off_n;
			front_s3.ti_low   <= ti_low_n;
			front_s3.ti_high  <= 17'(dtsq_s2 >> 36);
			// temp / 100 < 20 is the same as temp < 2000
			front_s3.low      <= dev_n[17];
			front_s3.cold     <= dev_n <= 18'(COLD_DEV_LIMIT);
		end
	end

	assign out_valid = v_s3;
	assign front = front_s3;

	`ASSERT_IMPL(a_cold_is_low, v_s3 && front_s3.cold, front_s3.low,
		"very-low temperature flagged without low temperature")

endmodule

// ----- sv/ptc_corr.sv -----
// ----------------------------------------------------------------------------
// ptc_corr
// stages 4 to 6: second-order temperature, offset and sensitivity corrections
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptc_corr
	import ptc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  front_t front,
	input  cal_t   cal,
	output logic   out_valid,
	output corr_t  corr
);

	logic               v_s4, v_s5, v_s6;
	logic [RAW_W-1:0]   d1_s4, d1_s5;
	logic signed [19:0] temp_s4, temp_s5;
	logic signed [35:0] sens_s4, sens_s5;
	logic signed [36:0] off_s4, off_s5;
	logic [33:0]        dev_sq_s4;
	logic [35:0]        cold_sq_s4;
	logic               low_s4, cold_s4, low_s5;
	logic [39:0]        offi_s5;
	logic [37:0]        sensi_s5;
	corr_t              corr_s6;

	logic signed [35:0] dev_full;
	logic signed [37:0] cold_full;
	logic [16:0]        ti_n;
	logic [39:0]        offi_n;
	logic [37:0]        sensi_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign dev_full  = front.dev * front.dev;
	assign cold_full = front.cold_dev * front.cold_dev;

	always_comb begin
		if (front.low) begin
			ti_n = front.ti_low;
		end else if (cal.sensor_model == MODEL_30BAR) begin
			ti_n = front.ti_high;
		end else begin
			ti_n = '0;
		end
	end

	always_comb begin
		offi_n  = '0;
		sensi_n = '0;
		if (cal.sensor_model == MODEL_2BAR) begin
			if (low_s4) begin
				offi_n  = 40'((40'(dev_sq_s4) * 40'd31) >> 3);
				sensi_n = 38'((40'(dev_sq_s4) * 40'd63) >> 5);
			end
		end else if (low_s4) begin
			offi_n  = 40'((40'(dev_sq_s4) * 40'd3) >> 1);
			sensi_n = 38'((38'(dev_sq_s4) * 38'd5) >> 3);
			if (cold_s4) begin
				offi_n  = offi_n + 40'(cold_sq_s4) * 40'd7;
				sensi_n = sensi_n + 38'(cold_sq_s4) * 38'd4;
			end
		end else begin
			offi_n = 40'(dev_sq_s4 >> 4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s4      <= front.d1;
			temp_s4    <= 20'(front.temp) - $signed({3'b0, ti_n});
			sens_s4    <= front.sens;
			off_s4     <= front.off;
			dev_sq_s4  <= dev_full[33:0];
			cold_sq_s4 <= cold_full[35:0];
			low_s4     <= front.low;
			cold_s4    <= front.cold;

			d1_s5    <= d1_s4;
			temp_s5  <= temp_s4;
			sens_s5  <= sens_s4;
			off_s5   <= off_s4;
			low_s5   <= low_s4;
			offi_s5  <= offi_n;
			sensi_s5 <= sensi_n;

			corr_s6.d1   <= d1_s5;
			corr_s6.temp <= temp_s5;
			corr_s6.sens <= 40'(sens_s5) - $signed({2'b0, sensi_s5});
			corr_s6.off  <= 41'(off_s5) - $signed({1'b0, offi_s5});
		end
	end

	assign out_valid = v_s6;
	assign corr = corr_s6;

	`ASSERT_IMPL(a_warm_2bar, v_s5 && cal.sensor_model == MODEL_2BAR && !low_s5,
		offi_s5 == '0 && sensi_s5 == '0, "2 bar model corrected above 20 degC")

endmodule

// ----- sv/ptc_press.sv -----
// ----------------------------------------------------------------------------
// ptc_press
// stages 7 to 11: d1 * sens in two partial products, scaling, output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptc_press
	import ptc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  corr_t   corr,
	input  cal_t    cal,
	output logic    out_valid,
	output result_t result
);

	logic               v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [43:0]        pp_lo_s7;
	logic signed [44:0] pp_hi_s7;
	logic signed [63:0] prod_s8;
	logic signed [42:0] scaled_s9;
	logic signed [43:0] diff_s10;
	logic signed [40:0] off_s7, off_s8, off_s9;
	logic signed [19:0] temp_s7, temp_s8, temp_s9, temp_s10;
	result_t            result_s11;

	logic signed [19:0] sens_hi;
	logic signed [63:0] p_n;

	assign sens_hi = corr.sens[39:20];

	always_comb begin
		if (cal.sensor_model == MODEL_2BAR) begin
			p_n = sdiv_pow2(64'(diff_s10), 15);
		end else begin
			p_n = sdiv_pow2(64'(diff_s10), 13);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s7  <= in_valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s7 <= corr.d1 * corr.sens[19:0];
			pp_hi_s7 <= $signed({1'b0, corr.d1}) * sens_hi;
			off_s7   <= corr.off;
			temp_s7  <= corr.temp;

			prod_s8 <= (64'(pp_hi_s7) <<< 20) + $signed({20'b0, pp_lo_s7});
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;

			scaled_s9 <= 43'(sdiv_pow2(prod_s8, 21));
			off_s9    <= off_s8;
			temp_s9   <= temp_s8;

			diff_s10 <= 44'(scaled_s9) - 44'(off_s9);
			temp_s10 <= temp_s9;

			result_s11.temperature_centi <= 32'(temp_s10);
			result_s11.pressure_value    <= p_n[RES_W-1:0];
		end
	end

	assign out_valid = v_s11;
	assign result = result_s11;

	`ASSERT_NEXT(a_freeze, !en, $stable(v_s11) && $stable(result_s11) && $stable(v_s10),
		"pipeline moved while frozen")

endmodule

// ----- sv/pressure_temperature_compensation_core.sv -----
// Throughput: one sample per cycle; a stalled result freezes the whole pipeline,
// so sample_stall follows result_stall while a result is waiting.
// Reset: arst_n clears all stage valid bits, the calibration words to zero and
// sensor_model to 1; payload registers are not reset.
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// second-order barometric pressure and temperature compensation pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pressure_temperature_compensation_core
	import ptc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	cal_t   cal;
	front_t front;
	corr_t  corr;
	logic   front_valid, corr_valid;
	logic   en;

	// the pipeline only holds when a finished transaction is refused
	assign en = !(result_valid && result_stall);
	assign sample_stall = !en;

	ptc_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cal          (cal)
	);

	ptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (sample_valid),
		.sample    (sample),
		.cal       (cal),
		.out_valid (front_valid),
		.front     (front)
	);

	ptc_corr u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.front     (front),
		.cal       (cal),
		.out_valid (corr_valid),
		.corr      (corr)
	);

	ptc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (corr_valid),
		.corr      (corr),
		.cal       (cal),
		.out_valid (result_valid),
		.result    (result)
	);

	`ASSERT_IMPL(a_stall_source, sample_stall, result_valid && result_stall,
		"sample stalled without a refused result")

endmodule

// ----- test/pressure_temperature_compensation_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_checker
// watches the calibration port and both the sample and result channels, predicts each
// compensated reading from its own copy of the calibration words and compares
// every result transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_checker
	import ptc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_data,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  sample_t              sample,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  result_t              result,
	output int                   fail_count,
	output int                   outstanding
);

	cal_t    cal_words;
	result_t pending_readings[$];
	int      errors;

	// second-order compensation in 64-bit signed arithmetic, c-style division
	function automatic result_t compensate_reading(input sample_t s, input cal_t c);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, sens, off, temp, dev, cold, ti, offi, sensi, divisor, p;
		result_t r;
		d1 = longint'(s.raw_pressure);
		d2 = longint'(s.raw_temperature);
		c1 = longint'(c.pressure_sensitivity);
		c2 = longint'(c.pressure_offset);
		c3 = longint'(c.sens_temp_coeff);
		c4 = longint'(c.offset_temp_coeff);
		c5 = longint'(c.reference_temperature);
		c6 = longint'(c.temp_sensitivity);
		ti = 0;
		offi = 0;
		sensi = 0;
		dt = d2 - c5 * 256;
		if (c.sensor_model == MODEL_2BAR) begin
			sens = c1 * 65536 + (c3 * dt) / 128;
			off = c2 * 131072 + (c4 * dt) / 64;
			divisor = 32768;
		end else begin
			sens = c1 * 32768 + (c3 * dt) / 256;
			off = c2 * 65536 + (c4 * dt) / 128;
			divisor = 8192;
		end
		temp = 2000 + (dt * c6) / 8388608;
		dev = (temp - 2000) * (temp - 2000);
		if (c.sensor_model == MODEL_2BAR) begin
			if (temp / 100 < 20) begin
				ti = (11 * dt * dt) / 64'sd34359738368;
				offi = (31 * dev) / 8;
				sensi = (63 * dev) / 32;
			end
		end else begin
			if (temp / 100 < 20) begin
				ti = (3 * dt * dt) / 64'sd8589934592;
				offi = (3 * dev) / 2;
				sensi = (5 * dev) / 8;
				// very cold branch follows the truncated division test
				if (temp / 100 < -15) begin
					cold = (temp + 1500) * (temp + 1500);
					offi = offi + 7 * cold;
					sensi = sensi + 4 * cold;
				end
			end else begin
				ti = (2 * dt * dt) / 64'sd137438953472;
				offi = dev / 16;
				sensi = 0;
			end
		end
		off = off - offi;
		sens = sens - sensi;
		temp = temp - ti;
		p = ((d1 * sens) / 2097152 - off) / divisor;
		r.temperature_centi = temp[31:0];
		r.pressure_value = p[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cal_words = '0;
			cal_words.sensor_model = MODEL_30BAR;
			pending_readings.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// result side first so a same-edge sample cannot satisfy itself
			if (result_valid && !result_stall) begin
				if (pending_readings.size() == 0) begin
					$display("%0t: unexpected result transaction temp %0d pressure %0d",
						$time, result.temperature_centi, result.pressure_value);
					errors++;
				end else begin
					want = pending_readings.pop_front();
					if (result.temperature_centi !== want.temperature_centi) begin
						$display("%0t: temperature_centi expected %0d got %0d",
							$time, want.temperature_centi, result.temperature_centi);
						errors++;
					end
					if (result.pressure_value !== want.pressure_value) begin
						$display("%0t: pressure_value expected %0d got %0d",
							$time, want.pressure_value, result.pressure_value);
						errors++;
					end
				end
			end
			if (sample_valid && !sample_stall)
				pending_readings.push_back(compensate_reading(sample, cal_words));
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_PRESSURE_SENSITIVITY:  cal_words.pressure_sensitivity = cfg_data;
					CFG_PRESSURE_OFFSET:       cal_words.pressure_offset = cfg_data;
					CFG_SENS_TEMP_COEFF:       cal_words.sens_temp_coeff = cfg_data;
					CFG_OFFSET_TEMP_COEFF:     cal_words.offset_temp_coeff = cfg_data;
					CFG_REFERENCE_TEMPERATURE: cal_words.reference_temperature = cfg_data;
					CFG_TEMP_SENSITIVITY:      cal_words.temp_sensitivity = cfg_data;
					CFG_SENSOR_MODEL:          cal_words.sensor_model = cfg_data[0];
					default: ;
				endcase
			end
			fail_count <= errors;
			outstanding <= pending_readings.size();
		end
	end

endmodule

// ----- test/pressure_temperature_compensation_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core_tb
// drives calibration sets and raw reading pairs into the compensation core,
// covering reset defaults, corner readings, every temperature branch of both
// sensor models and long random phases with idle and stall bursts
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core_tb;
	import ptc_pkg::*;

	localparam int PIPE_LATENCY = 11;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 108;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0]     cfg_data;
	logic                 sample_valid;
	logic                 sample_stall;
	sample_t              sample;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	int                   fail_count;
	int                   outstanding;
	logic                 idling_on;

	pressure_temperature_compensation_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	pressure_temperature_compensation_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// raw temperature giving the wanted centi-degrees with ref 0x8000 and c6 0x8000
	function automatic logic [RAW_W-1:0] reading_for_centi(input int centi);
		return RAW_W'(8388608 + (centi - 2000) * 256);
	endfunction

	function automatic logic [CAL_W-1:0] random_cal_word();
		int pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0: return '0;
			1: return '1;
			2, 3: return CAL_W'($urandom_range(20000, 50000));
			default: return CAL_W'($urandom);
		endcase
	endfunction

	task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{raw_pressure: d1, raw_temperature: d2};
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	// stop sending and wait for every result, then let the pipeline settle
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic load_calibration(input cal_t c);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_PRESSURE_SENSITIVITY;
		cfg_data <= c.pressure_sensitivity;
		@(posedge clk);
		cfg_index <= CFG_PRESSURE_OFFSET;
		cfg_data <= c.pressure_offset;
		@(posedge clk);
		cfg_index <= CFG_SENS_TEMP_COEFF;
		cfg_data <= c.sens_temp_coeff;
		@(posedge clk);
		cfg_index <= CFG_OFFSET_TEMP_COEFF;
		cfg_data <= c.offset_temp_coeff;
		@(posedge clk);
		cfg_index <= CFG_REFERENCE_TEMPERATURE;
		cfg_data <= c.reference_temperature;
		@(posedge clk);
		cfg_index <= CFG_TEMP_SENSITIVITY;
		cfg_data <= c.temp_sensitivity;
		@(posedge clk);
		// upper bits of the model word are don't-care
		cfg_index <= CFG_SENSOR_MODEL;
		cfg_data <= {15'($urandom), c.sensor_model};
		@(posedge clk);
		// index past the register list must be ignored
		cfg_index <= CFG_UNUSED_INDEX;
		cfg_data <= CAL_W'($urandom);
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// result side stall bursts
	initial begin
		int hold;
		hold = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else if (idling_on && $urandom_range(0, 9) == 0)
				hold = $urandom_range(1, 17);
			result_stall <= (hold > 0);
		end
	end

	// ends the run when no transaction of any kind moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| cfg_write_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		cal_t cal;
		int target;
		logic [RAW_W-1:0] d2;
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= CFG_PRESSURE_SENSITIVITY;
		cfg_data <= '0;
		sample_valid <= 1'b0;
		sample <= '0;
		idling_on <= 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset calibration: all words zero, high range model
		send_reading('1, RAW_W'($urandom));
		send_reading(RAW_W'($urandom), RAW_W'($urandom));
		drain();

		// corner readings and every temperature branch under both models
		for (int m = 0; m < 2; m++) begin
			cal.pressure_sensitivity = 16'd34982;
			cal.pressure_offset = 16'd36352;
			cal.sens_temp_coeff = 16'd20328;
			cal.offset_temp_coeff = 16'd22354;
			cal.reference_temperature = 16'h8000;
			cal.temp_sensitivity = 16'h8000;
			cal.sensor_model = (m == 0) ? MODEL_2BAR : MODEL_30BAR;
			load_calibration(cal);
			send_reading('0, '0);
			send_reading('1, '1);
			send_reading('0, '1);
			send_reading('1, '0);
			send_reading(24'd4958179, reading_for_centi(2000));
			send_reading(24'd4958179, reading_for_centi(1999));
			send_reading(24'd4958179, reading_for_centi(-99));
			// truncated division puts -1599 above the very cold limit, -1600 below
			send_reading(24'd4958179, reading_for_centi(-1599));
			send_reading(24'd4958179, reading_for_centi(-1600));
			send_reading(24'd4958179, reading_for_centi(4000));
			send_reading(24'd4958179, reading_for_centi(-4000));
			drain();
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			idling_on <= (p < NUM_PHASES - 2) && (p % 4 != 3);
			if (p < 4) begin
				// extreme calibration sets, each under both models
				cal = (p == 1 || p == 2) ? '1 : '0;
				cal.sensor_model = p[0];
			end else begin
				cal.pressure_sensitivity = random_cal_word();
				cal.pressure_offset = random_cal_word();
				cal.sens_temp_coeff = random_cal_word();
				cal.offset_temp_coeff = random_cal_word();
				cal.reference_temperature = random_cal_word();
				cal.temp_sensitivity = random_cal_word();
				cal.sensor_model = $urandom_range(0, 1);
			end
			load_calibration(cal);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				case ($urandom_range(0, 9))
					0: d2 = '0;
					1: d2 = '1;
					2, 3, 4, 5: begin
						// near the reference temperature to spread over the branches
						target = int'(cal.reference_temperature) * 256
							+ int'($urandom_range(0, 2097152)) - 1048576;
						if (target < 0)
							target = 0;
						else if (target > 16777215)
							target = 16777215;
						d2 = RAW_W'(target);
					end
					default: d2 = RAW_W'($urandom);
				endcase
				send_reading(($urandom_range(0, 15) == 0) ? '1 : RAW_W'($urandom), d2);
			end
			drain();
		end

		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ptc_pkg.sv
sv/ptc_cfg.sv
sv/ptc_front.sv
sv/ptc_corr.sv
sv/ptc_press.sv
sv/pressure_temperature_compensation_core.sv
test/pressure_temperature_compensation_checker.sv
test/pressure_temperature_compensation_core_tb.sv
